// File: hw/rtl/prq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the packet ring queue.
// No dependencies; used by prq_ctrl, prq_dp and packet_ring_queue.
package prq_pkg;

    // Field widths of the input and result items.
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 6;
    localparam int QCNT_W   = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQ    = 2'd2;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic range_err;
        logic too_large;
        logic at_last;
        logic out_free;
    } prq_stat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                emit_single;
        logic [STATUS_W-1:0] single_code;
        logic                push_store;
        logic                commit_store;
        logic                build_clear;
        logic                start_stream;
        logic                pop;
        logic                load_len;
        logic                emit_stream;
    } prq_cmd_t;

endpackage

// File: hw/rtl/prq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the packet ring queue.
// Depends on prq_pkg for the command and status structs and the codes.
module prq_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic [prq_pkg::OP_W-1:0] in_op,
    output logic                     in_ready,
    input  prq_pkg::prq_stat_t       stat,
    output prq_pkg::prq_cmd_t        cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LEN    = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // Items are taken only in idle and only when the output register can be loaded.
    assign in_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        prq_pkg::OP_PUSH: begin
                            cmd.emit_single = 1'b1;
                            cmd.single_code = stat.full ? prq_pkg::ST_FULL : prq_pkg::ST_OK;
                            cmd.push_store  = !stat.full;
                        end
                        prq_pkg::OP_COMMIT: begin
                            cmd.emit_single  = 1'b1;
                            cmd.build_clear  = 1'b1;
                            cmd.commit_store = !stat.full && !stat.too_large;
                            if (stat.full) begin
                                cmd.single_code = prq_pkg::ST_FULL;
                            end else if (stat.too_large) begin
                                cmd.single_code = prq_pkg::ST_TOO_LARGE;
                            end else begin
                                cmd.single_code = prq_pkg::ST_OK;
                            end
                        end
                        prq_pkg::OP_DEQ: begin
                            if (stat.empty) begin
                                cmd.emit_single = 1'b1;
                                cmd.single_code = prq_pkg::ST_EMPTY;
                            end else begin
                                cmd.start_stream = 1'b1;
                                cmd.pop          = 1'b1;
                                state_next       = S_LEN;
                            end
                        end
                        prq_pkg::OP_PEEK: begin
                            if (stat.empty) begin
                                cmd.emit_single = 1'b1;
                                cmd.single_code = prq_pkg::ST_EMPTY;
                            end else if (stat.range_err) begin
                                cmd.emit_single = 1'b1;
                                cmd.single_code = prq_pkg::ST_RANGE;
                            end else begin
                                cmd.start_stream = 1'b1;
                                state_next       = S_LEN;
                            end
                        end
                        default: begin
                            cmd.emit_single = 1'b0;
                        end
                    endcase
                end
            end
            S_LEN: begin
                cmd.load_len = 1'b1;
                state_next   = S_STREAM;
            end
            S_STREAM: begin
                if (stat.out_free) begin
                    cmd.emit_stream = 1'b1;
                    if (stat.at_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // A started stream always passes through the length read.
    a_start_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_stream |=> state_reg == S_LEN)
        else $error("stream start did not enter the length read");

    // The final streamed result returns the controller to idle.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_stream && stat.at_last) |=> state_reg == S_IDLE)
        else $error("controller did not return to idle after the last result");

    // No item is taken while a stream is in progress.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LEN || state_reg == S_STREAM) |-> !in_ready)
        else $error("item taken during a stream");
`endif

endmodule

// File: hw/rtl/prq_dp.sv
`timescale 1ns / 1ps
// Datapath of the packet ring queue: pointers, counts, memories, output register.
// Depends on prq_pkg for the command and status structs and field widths.
module prq_dp #(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_BYTES = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [prq_pkg::BYTE_W-1:0]   data_byte,
    input  logic [prq_pkg::IDX_W-1:0]    pkt_index,
    input  prq_pkg::prq_cmd_t            cmd,
    output prq_pkg::prq_stat_t           stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [prq_pkg::STATUS_W-1:0] out_status,
    output logic [prq_pkg::BYTE_W-1:0]   out_byte,
    output logic                         out_byte_valid,
    output logic [prq_pkg::LEN_W-1:0]    out_pkt_length,
    output logic                         out_last,
    output logic [prq_pkg::QCNT_W-1:0]   out_queue_count
);

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int OFF_W   = $clog2(SLOT_BYTES);
    localparam int ADDR_W  = SLOT_W + OFF_W;
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int BC_W    = $clog2(SLOT_BYTES + 1);
    localparam int IW      = prq_pkg::IDX_W;
    localparam int QW      = prq_pkg::QCNT_W;
    localparam int LW      = prq_pkg::LEN_W;
    localparam int SUM_W   = ((SLOT_W > IW) ? SLOT_W : IW) + 1;
    localparam int CMP_W   = (CNT_W > IW) ? CNT_W : IW;
    localparam int EXT_W   = (CNT_W > QW) ? CNT_W : QW;

    // Packet bytes, one row of 2**OFF_W bytes per slot, and per-slot lengths.
    logic [prq_pkg::BYTE_W-1:0] pkt_mem [2**ADDR_W];
    logic [OFF_W-1:0]           len_mem [SLOT_COUNT];

    logic [CNT_W-1:0]  held_reg, held_next;
    logic [BC_W-1:0]   build_reg, build_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [OFF_W-1:0]  idx_reg;
    logic [OFF_W-1:0]  len_reg;
    logic [OFF_W-1:0]  len_rd_reg;
    logic [prq_pkg::BYTE_W-1:0] pkt_rd_reg;
    logic              out_valid_reg, out_valid_next;
    logic [prq_pkg::STATUS_W-1:0] status_reg;
    logic [prq_pkg::BYTE_W-1:0]   byte_reg;
    logic              byte_valid_reg;
    logic [LW-1:0]     length_reg;
    logic              last_reg;
    logic [QW-1:0]     qcnt_reg;

    logic [SUM_W-1:0]  peek_sum;
    logic [SUM_W-1:0]  peek_wrap;
    logic [SLOT_W-1:0] target_slot;
    logic [OFF_W:0]    idx_inc;
    logic              pkt_we, pkt_re;
    logic [ADDR_W-1:0] pkt_waddr, pkt_raddr;
    logic [EXT_W-1:0]  held_ext_next, held_ext;

    // Status towards the controller.
    assign idx_inc         = {1'b0, idx_reg} + {{OFF_W{1'b0}}, 1'b1};
    assign stat.full       = (held_reg == CNT_W'(SLOT_COUNT));
    assign stat.empty      = (held_reg == '0);
    assign stat.range_err  = (CMP_W'(pkt_index) >= CMP_W'(held_reg));
    assign stat.too_large  = (build_reg >= BC_W'(SLOT_BYTES));
    assign stat.at_last    = (len_reg == '0) || (idx_inc == {1'b0, len_reg});
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Slot addressed by a dequeue or a peek, wrapped round the ring.
    always_comb begin
        peek_sum  = SUM_W'(rd_slot_reg) + SUM_W'(pkt_index);
        peek_wrap = (peek_sum >= SUM_W'(SLOT_COUNT)) ? peek_sum - SUM_W'(SLOT_COUNT)
                                                      : peek_sum;
        target_slot = cmd.pop ? rd_slot_reg : peek_wrap[SLOT_W-1:0];
    end

    // Pointer and count updates.
    always_comb begin
        held_next    = held_reg;
        build_next   = build_reg;
        rd_slot_next = rd_slot_reg;
        wr_slot_next = wr_slot_reg;
        if (cmd.push_store && build_reg < BC_W'(SLOT_BYTES)) begin
            build_next = build_reg + {{(BC_W-1){1'b0}}, 1'b1};
        end
        if (cmd.build_clear) begin
            build_next = '0;
        end
        if (cmd.commit_store) begin
            held_next    = held_reg + {{(CNT_W-1){1'b0}}, 1'b1};
            wr_slot_next = (wr_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0
                         : wr_slot_reg + {{(SLOT_W-1){1'b0}}, 1'b1};
        end
        if (cmd.pop) begin
            held_next    = held_reg - {{(CNT_W-1){1'b0}}, 1'b1};
            rd_slot_next = (rd_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0
                         : rd_slot_reg + {{(SLOT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            build_reg   <= '0;
            rd_slot_reg <= '0;
            wr_slot_reg <= '0;
        end else begin
            held_reg    <= held_next;
            build_reg   <= build_next;
            rd_slot_reg <= rd_slot_next;
            wr_slot_reg <= wr_slot_next;
        end
    end

    // Packet memory: bytes past the last storable position are not written.
    assign pkt_we    = cmd.push_store && (build_reg < BC_W'(SLOT_BYTES - 1));
    assign pkt_waddr = {wr_slot_reg, build_reg[OFF_W-1:0]};
    assign pkt_re    = cmd.load_len || cmd.emit_stream;
    assign pkt_raddr = cmd.load_len ? {slot_reg, {OFF_W{1'b0}}}
                                    : {slot_reg, idx_inc[OFF_W-1:0]};

    always_ff @(posedge aclk) begin
        if (pkt_we) begin
            pkt_mem[pkt_waddr] <= data_byte;
        end
        if (pkt_re) begin
            pkt_rd_reg <= pkt_mem[pkt_raddr];
        end
    end

    // Length memory.
    always_ff @(posedge aclk) begin
        if (cmd.commit_store) begin
            len_mem[wr_slot_reg] <= build_reg[OFF_W-1:0];
        end
        if (cmd.start_stream) begin
            len_rd_reg <= len_mem[target_slot];
        end
    end

    // Stream position.
    always_ff @(posedge aclk) begin
        if (cmd.start_stream) begin
            slot_reg <= target_slot;
        end
        if (cmd.load_len) begin
            len_reg <= len_rd_reg;
            idx_reg <= '0;
        end else if (cmd.emit_stream) begin
            idx_reg <= idx_inc[OFF_W-1:0];
        end
    end

    // Output register.
    assign held_ext_next = EXT_W'(held_next);
    assign held_ext      = EXT_W'(held_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_single || cmd.emit_stream) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_single) begin
            status_reg     <= cmd.single_code;
            byte_reg       <= '0;
            byte_valid_reg <= 1'b0;
            length_reg     <= '0;
            last_reg       <= 1'b1;
            qcnt_reg       <= held_ext_next[QW-1:0];
        end else if (cmd.emit_stream) begin
            status_reg     <= prq_pkg::ST_OK;
            byte_reg       <= (len_reg == '0) ? '0 : pkt_rd_reg;
            byte_valid_reg <= (len_reg != '0);
            length_reg     <= LW'(len_reg);
            last_reg       <= stat.at_last;
            qcnt_reg       <= held_ext[QW-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = status_reg;
    assign out_byte        = byte_reg;
    assign out_byte_valid  = byte_valid_reg;
    assign out_pkt_length  = length_reg;
    assign out_last        = last_reg;
    assign out_queue_count = qcnt_reg;

`ifndef SYNTH
    // The ring never holds more packets than it has slots.
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(SLOT_COUNT))
        else $error("held count exceeds the slot count");

    // The build count saturates at the slot size.
    a_build_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        build_reg <= BC_W'(SLOT_BYTES))
        else $error("build count exceeds the slot size");

    // A streamed byte always lies inside the stored packet.
    a_idx_in_pkt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_stream && len_reg != '0) |-> idx_reg < len_reg)
        else $error("stream index beyond packet length");

    // The output register is only loaded when it is free.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_single || cmd.emit_stream) |-> stat.out_free)
        else $error("output register overwritten while held");
`endif

endmodule

// File: hw/rtl/packet_ring_queue.sv
`timescale 1ns / 1ps
// Top level of the packet ring queue: stream ports, controller and datapath.
// Depends on prq_pkg, prq_ctrl and prq_dp.
//
//  channel | direction | tdata (low bit up)                           | tuser      | tlast
//  s_      | in        | data_byte[7:0], pkt_index[11:8]              | op[1:0]    | -
//  m_      | out       | status[2:0], out_byte[10:3],                 | byte_valid | last
//          |           | pkt_length[16:11], queue_count[21:17]        |            |
//
// Push and commit, and dequeue or peek that fail, give a single result each.
// A dequeue or peek of a packet of L bytes gives max(L, 1) results: the accept
// reads the length memory, the length state fetches the first byte from the
// registered packet memory read, then one result per cycle while m_tready allows.
// Reset clears the pointers and counts at once; the memories are not cleared.
// A stall on m_tready holds the stream; the next item is taken in the cycle
// after the last result of the current one has been loaded into the output
// register, once that register is free or being read.
module packet_ring_queue #(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], pkt_index[11:8], zero fill
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[2:0], out_byte[10:3], pkt_length[16:11],
                                   // queue_count[21:17], zero fill
    output logic [0:0]  m_tuser,   // byte_valid
    output logic        m_tlast
);

    prq_pkg::prq_cmd_t  cmd;
    prq_pkg::prq_stat_t stat;

    logic [prq_pkg::STATUS_W-1:0] out_status;
    logic [prq_pkg::BYTE_W-1:0]   out_byte;
    logic                         out_byte_valid;
    logic [prq_pkg::LEN_W-1:0]    out_pkt_length;
    logic [prq_pkg::QCNT_W-1:0]   out_queue_count;

    // Sequencing of each item.
    prq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and result formation.
    prq_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .data_byte       (s_tdata[7:0]),
        .pkt_index       (s_tdata[11:8]),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (out_status),
        .out_byte        (out_byte),
        .out_byte_valid  (out_byte_valid),
        .out_pkt_length  (out_pkt_length),
        .out_last        (m_tlast),
        .out_queue_count (out_queue_count)
    );

    // Result packing.
    assign m_tdata = {2'b00, out_queue_count, out_pkt_length, out_byte, out_status};
    assign m_tuser = out_byte_valid;

endmodule
